FILE: rtl/frla_pkg.sv
`timescale 1ns / 1ps

package frla_pkg;

	localparam int QUAL_W  = 8;
	localparam int TIME_W  = 32;
	localparam int FLOW_W  = 24;
	localparam int QOUT_W  = 9;
	localparam int RATE_W  = 10;
	localparam int QSUM_W  = 24;
	localparam int COUNT_W = 16;
	localparam int PROD_W  = TIME_W + RATE_W;

	localparam logic [PROD_W-1:0]        ONE_MILLION = PROD_W'(1000000);
	localparam logic signed [QOUT_W-1:0] QUAL_HOLD   = -9'sd1;

	typedef struct packed {
		logic [QUAL_W-1:0]        quality_in;
		logic [TIME_W-1:0]        frame_time;
		logic signed [FLOW_W-1:0] flow_x_in;
		logic signed [FLOW_W-1:0] flow_y_in;
	} frla_in_t;

	typedef struct packed {
		logic signed [QOUT_W-1:0] quality_out;
		logic [TIME_W-1:0]        delta_time;
		logic                     delta_valid;
		logic signed [FLOW_W-1:0] flow_x_out;
		logic signed [FLOW_W-1:0] flow_y_out;
	} frla_out_t;

	typedef struct packed {
		logic load;
		logic accum;
		logic mul;
		logic div_start;
		logic finish;
	} frla_cmd_t;

	typedef struct packed {
		logic last_zero;
		logic rate_zero;
		logic qual_zero;
		logic over;
		logic count_zero;
		logic div_done;
		logic out_free;
	} frla_sts_t;

endpackage

FILE: rtl/frla_stream_if.sv
`timescale 1ns / 1ps

interface frla_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/frla_div.sv
`timescale 1ns / 1ps

module frla_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [frla_pkg::QSUM_W-1:0]    dividend,
	input  logic [frla_pkg::COUNT_W-1:0]   divisor,
	output logic                           busy,
	output logic                           done,
	output logic [frla_pkg::QSUM_W-1:0]    quotient
);
	import frla_pkg::*;

	localparam int CNT_W = $clog2(QSUM_W);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COUNT_W-1:0] rem_q;
	logic [QSUM_W-1:0]  quo_q;
	logic [COUNT_W-1:0] dsr_q;
	logic [COUNT_W:0]   trial;
	logic               fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[QSUM_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QSUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? COUNT_W'(trial - {1'b0, dsr_q}) : trial[COUNT_W-1:0];
			quo_q <= {quo_q[QSUM_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

endmodule

FILE: rtl/frla_dp.sv
`timescale 1ns / 1ps

module frla_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  frla_pkg::frla_cmd_t           cmd,
	output frla_pkg::frla_sts_t           sts,
	input  frla_pkg::frla_in_t            in_item,
	input  logic                          cfg_we,
	input  logic [frla_pkg::RATE_W-1:0]   cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output frla_pkg::frla_out_t           out_item
);
	import frla_pkg::*;

	logic [RATE_W-1:0]        rate_q;
	logic [TIME_W-1:0]        last_time_q;
	logic signed [FLOW_W-1:0] sum_x_q;
	logic signed [FLOW_W-1:0] sum_y_q;
	logic [QSUM_W-1:0]        sum_q_q;
	logic [COUNT_W-1:0]       count_q;
	frla_in_t                 in_q;
	logic [PROD_W-1:0]        prod_s1;
	logic                     out_valid_q;
	frla_out_t                out_q;

	logic [TIME_W-1:0]        dt;
	logic                     over;
	logic                     emit;
	logic [QSUM_W:0]          qsum_ext;
	logic [QSUM_W-1:0]        qsum_sat;
	logic [QUAL_W-1:0]        avg;
	logic                     div_busy;
	logic                     div_done;
	logic [QSUM_W-1:0]        quotient;
	frla_out_t                res;

	function automatic logic signed [FLOW_W-1:0] sat_add(
		input logic signed [FLOW_W-1:0] a,
		input logic signed [FLOW_W-1:0] b
	);
		logic signed [FLOW_W:0] s;
		s = {a[FLOW_W-1], a} + {b[FLOW_W-1], b};
		if (s[FLOW_W] != s[FLOW_W-1]) begin
			sat_add = s[FLOW_W] ? {1'b1, {(FLOW_W-1){1'b0}}} : {1'b0, {(FLOW_W-1){1'b1}}};
		end else begin
			sat_add = s[FLOW_W-1:0];
		end
	endfunction

	frla_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	assign dt       = in_q.frame_time - last_time_q;
	assign over     = prod_s1 > ONE_MILLION;
	assign emit     = (last_time_q != '0) && (rate_q != '0) && over;
	assign qsum_ext = {1'b0, sum_q_q} + (QSUM_W + 1)'(in_q.quality_in);
	assign qsum_sat = qsum_ext[QSUM_W] ? '1 : qsum_ext[QSUM_W-1:0];
	assign avg      = (count_q == '0) ? '0 :
		(quotient[QSUM_W-1:QUAL_W] != '0) ? '1 : quotient[QUAL_W-1:0];

	assign sts.last_zero  = last_time_q == '0;
	assign sts.rate_zero  = rate_q == '0;
	assign sts.qual_zero  = in_q.quality_in == '0;
	assign sts.over       = over;
	assign sts.count_zero = count_q == '0;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || out_ready;

	always_comb begin
		res.quality_out = {1'b0, in_q.quality_in};
		res.delta_time  = '0;
		res.delta_valid = 1'b0;
		res.flow_x_out  = in_q.flow_x_in;
		res.flow_y_out  = in_q.flow_y_in;
		if (last_time_q == '0) begin
			res.delta_valid = 1'b0;
		end else if (rate_q == '0) begin
			res.delta_time  = dt;
			res.delta_valid = 1'b1;
		end else if (over) begin
			res.quality_out = {1'b0, avg};
			res.delta_time  = dt;
			res.delta_valid = 1'b1;
			res.flow_x_out  = sum_x_q;
			res.flow_y_out  = sum_y_q;
		end else begin
			res.quality_out = QUAL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
		end else if (cfg_we) begin
			rate_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_item;
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(dt) * PROD_W'(rate_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_q_q     <= '0;
			count_q     <= '0;
		end else if (cmd.accum) begin
			sum_x_q <= sat_add(sum_x_q, in_q.flow_x_in);
			sum_y_q <= sat_add(sum_y_q, in_q.flow_y_in);
			sum_q_q <= qsum_sat;
			if (count_q != '1) begin
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.finish) begin
			if ((last_time_q == '0) || (rate_q == '0) || emit) begin
				last_time_q <= in_q.frame_time;
			end
			if (emit) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_q_q <= '0;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken result");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("result register not marked valid");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && emit) |=> (count_q == '0 && sum_q_q == '0))
		else $error("sums not cleared after output");

endmodule

FILE: rtl/frla_ctrl.sv
`timescale 1ns / 1ps

module frla_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  frla_pkg::frla_sts_t sts,
	output frla_pkg::frla_cmd_t cmd
);
	import frla_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_TEST = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       limited;

	assign limited = !sts.last_zero && !sts.rate_zero;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.accum = limited && !sts.qual_zero;
				cmd.mul   = 1'b1;
				state_d   = S_TEST;
			end
			S_TEST: begin
				if (limited && sts.over && !sts.count_zero) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/flow_rate_limit_accumulator.sv
`timescale 1ns / 1ps

// channel   dir  payload
// in_ch     in   quality_in, frame_time, flow_x_in, flow_y_in
// out_ch    out  quality_out, delta_time, delta_valid, flow_x_out, flow_y_out
// cfg       in   cfg_we, cfg_wdata (output_rate_hz)
//
// one frame at a time; a frame whose output averages a nonzero count also
// waits for the 24-step serial quality divider
// arst_n clears rate, last time, sums, count and the output valid
// the result sits in an output register, so the next frame is taken
// while the last result waits; a result waits in place while out_ch stalls

module flow_rate_limit_accumulator (
	input  logic                        clk,
	input  logic                        arst_n,
	frla_stream_if.sink                 in_ch,
	frla_stream_if.source               out_ch,
	input  logic                        cfg_we,
	input  logic [frla_pkg::RATE_W-1:0] cfg_wdata
);
	import frla_pkg::*;

	frla_cmd_t cmd;
	frla_sts_t sts;

	frla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	frla_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_ch.payload),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_ch.payload)
	);

endmodule

FILE: tb/sv/tb_flow_rate_limit_accumulator.sv
`timescale 1ns / 1ps

module tb_flow_rate_limit_accumulator;

	import frla_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_500_000;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam logic signed [FLOW_W-1:0] FLOW_TOP = 24'sh7FFFFF;
	localparam logic signed [FLOW_W-1:0] FLOW_BOTTOM = 24'sh800000;
	localparam logic [RATE_W-1:0] RATE_OFF = '0;
	localparam logic [RATE_W-1:0] RATE_SLOWEST = 10'd1;
	localparam logic [RATE_W-1:0] RATE_FASTEST = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [RATE_W-1:0] cfg_wdata;

	frla_stream_if #(.payload_t(frla_in_t)) frame_ch ();
	frla_stream_if #(.payload_t(frla_out_t)) result_ch ();

	flow_rate_limit_accumulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(frame_ch),
		.out_ch(result_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [RATE_W-1:0] rate_hz;
	logic [TIME_W-1:0] last_stamp;
	logic signed [FLOW_W-1:0] acc_x;
	logic signed [FLOW_W-1:0] acc_y;
	logic [QSUM_W-1:0] acc_q;
	logic [COUNT_W-1:0] n_valid;

	frla_in_t pending_frames[$];
	frla_out_t expected_results[$];

	bit no_idle;
	bit in_taken;
	int unsigned in_gap;
	int unsigned stall_left;
	logic [TIME_W-1:0] clock_us;

	int unsigned cycle_count;
	int unsigned frames_taken;
	int unsigned results_seen;
	int unsigned publishes;
	int unsigned holds;
	int unsigned mismatches;
	int unsigned rate_writes;

	function automatic logic signed [FLOW_W-1:0] sat_flow(input logic signed [FLOW_W-1:0] a,
			input logic signed [FLOW_W-1:0] b);
		logic signed [FLOW_W:0] s;
		s = a + b;
		if (s > FLOW_TOP)
			return FLOW_TOP;
		if (s < FLOW_BOTTOM)
			return FLOW_BOTTOM;
		return s[FLOW_W-1:0];
	endfunction

	function automatic frla_out_t predict_frame(input frla_in_t f);
		frla_out_t r;
		logic [TIME_W-1:0] dt;
		logic [QSUM_W:0] qsum;
		logic [31:0] avg;
		r.quality_out = {1'b0, f.quality_in};
		r.delta_time = '0;
		r.delta_valid = 1'b0;
		r.flow_x_out = f.flow_x_in;
		r.flow_y_out = f.flow_y_in;
		dt = f.frame_time - last_stamp;
		if (last_stamp == '0) begin
			last_stamp = f.frame_time;
		end else if (rate_hz == '0) begin
			r.delta_time = dt;
			r.delta_valid = 1'b1;
			last_stamp = f.frame_time;
		end else begin
			if (f.quality_in != '0) begin
				acc_x = sat_flow(acc_x, f.flow_x_in);
				acc_y = sat_flow(acc_y, f.flow_y_in);
				qsum = {1'b0, acc_q} + f.quality_in;
				acc_q = qsum[QSUM_W] ? '1 : qsum[QSUM_W-1:0];
				if (n_valid != '1)
					n_valid++;
			end
			if (64'(dt) * 64'(rate_hz) > 64'(ONE_MILLION)) begin
				avg = (n_valid == '0) ? 32'd0 : 32'(acc_q) / 32'(n_valid);
				if (avg > 32'd255)
					avg = 32'd255;
				r.quality_out = 9'(avg);
				r.flow_x_out = acc_x;
				r.flow_y_out = acc_y;
				acc_x = '0;
				acc_y = '0;
				acc_q = '0;
				n_valid = '0;
				r.delta_time = dt;
				r.delta_valid = 1'b1;
				last_stamp = f.frame_time;
			end else begin
				r.quality_out = QUAL_HOLD;
			end
		end
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [FLOW_W-1:0] rand_flow();
		case ($urandom_range(0, 9))
		0: return FLOW_TOP;
		1: return FLOW_BOTTOM;
		2, 3: return 24'(int'($urandom_range(0, 4000)) - 2000);
		default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [QUAL_W-1:0] rand_quality();
		case ($urandom_range(0, 19))
		0, 1, 2, 3: return '0;
		4, 5: return '1;
		6: return 8'd1;
		default: return 8'($urandom_range(1, 254));
		endcase
	endfunction

	task automatic add_frame(input logic [QUAL_W-1:0] q, input logic [TIME_W-1:0] t,
			input logic signed [FLOW_W-1:0] x, input logic signed [FLOW_W-1:0] y);
		frla_in_t f;
		f.quality_in = q;
		f.frame_time = t;
		f.flow_x_in = x;
		f.flow_y_in = y;
		pending_frames.push_back(f);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] r);
		@(negedge clk);
		cfg_wdata <= r;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		rate_hz = r;
		rate_writes++;
	endtask

	task automatic drain();
		while (pending_frames.size() != 0 || frame_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random_frames(input int unsigned count, input logic [RATE_W-1:0] r);
		int unsigned span;
		span = (r == '0) ? 1000 : 1000000 / r;
		repeat (count) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3: clock_us += $urandom_range(0, span / 3 + 1);
			4, 5: clock_us += span + $urandom_range(0, 1);
			6, 7: clock_us += $urandom_range(span, 3 * span);
			8: clock_us += $urandom();
			default: clock_us = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
			endcase
			add_frame(rand_quality(), clock_us, rand_flow(), rand_flow());
		end
	endtask

	task check_field(input string field, input logic signed [32:0] want,
			input logic signed [32:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d %s: expected %0d, got %0d", results_seen, field, want, got);
		end
	endtask

	// frame driver
	always @(negedge clk) begin : drive_frames
		logic send_valid;
		frla_in_t send_item;
		send_valid = frame_ch.valid;
		send_item = frame_ch.payload;
		if (!arst_n) begin
			send_valid = 1'b0;
		end else begin
			if (send_valid && in_taken)
				send_valid = 1'b0;
			if (!send_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_frames.size() != 0) begin
					send_item = pending_frames.pop_front();
					send_valid = 1'b1;
					in_gap = pick_gap();
				end
			end
		end
		in_taken = 1'b0;
		frame_ch.valid <= send_valid;
		frame_ch.payload <= send_item;
	end

	// result sink with random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			stall_left = pick_gap();
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch_channels
		frla_out_t want;
		frla_out_t got;
		cycle_count++;
		if (result_ch.valid && result_ch.ready) begin
			got = result_ch.payload;
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no frame outstanding", results_seen);
			end else begin
				want = expected_results.pop_front();
				if (want.delta_valid)
					publishes++;
				if (want.quality_out == QUAL_HOLD)
					holds++;
				check_field("quality_out", want.quality_out, got.quality_out);
				check_field("delta_time", {1'b0, want.delta_time}, {1'b0, got.delta_time});
				check_field("delta_valid", {32'd0, want.delta_valid}, {32'd0, got.delta_valid});
				check_field("flow_x_out", want.flow_x_out, got.flow_x_out);
				check_field("flow_y_out", want.flow_y_out, got.flow_y_out);
			end
		end
		if (frame_ch.valid && frame_ch.ready) begin
			expected_results.push_back(predict_frame(frame_ch.payload));
			frames_taken++;
			in_taken = 1'b1;
		end
	end

	initial begin
		do
			@(posedge clk);
		while (cycle_count < CYCLE_LIMIT);
		$display("timed out after %0d cycles with %0d results outstanding", cycle_count,
			expected_results.size());
		$display("tb_flow_rate_limit_accumulator: errors");
		$finish;
	end

	initial begin : stimulus
		logic [RATE_W-1:0] r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		frame_ch.valid = 1'b0;
		frame_ch.payload = '0;
		result_ch.ready = 1'b0;
		rate_hz = '0;
		last_stamp = '0;
		acc_x = '0;
		acc_y = '0;
		acc_q = '0;
		n_valid = '0;
		no_idle = 1'b0;
		in_taken = 1'b0;
		in_gap = 0;
		stall_left = 0;
		clock_us = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pass-through, zero stamp, first frame and wrap
		write_rate(RATE_OFF);
		add_frame(8'd0, 32'd0, 24'sd0, 24'sd0);
		add_frame(8'd255, 32'd100, FLOW_TOP, FLOW_BOTTOM);
		add_frame(8'd0, 32'd250, FLOW_BOTTOM, FLOW_TOP);
		add_frame(8'd1, 32'hFFFF_FFF0, 24'sd5, -24'sd5);
		add_frame(8'd128, 32'd5, -24'sd1, 24'sd1);
		drain();

		// hold, threshold boundary, empty average, saturating sums
		write_rate(10'd1000);
		add_frame(8'd10, 32'd505, 24'sd1000, -24'sd1000);
		add_frame(8'd0, 32'd1505, 24'sd7, 24'sd7);
		add_frame(8'd0, 32'd2505, 24'sd9, 24'sd9);
		add_frame(8'd0, 32'd2506, 24'sd3, 24'sd3);
		add_frame(8'd255, 32'd2600, FLOW_TOP, FLOW_BOTTOM);
		add_frame(8'd255, 32'd2700, FLOW_TOP, FLOW_BOTTOM);
		add_frame(8'd255, 32'd2800, FLOW_TOP, FLOW_BOTTOM);
		add_frame(8'd200, 32'd3600, FLOW_BOTTOM, FLOW_TOP);
		drain();

		// fastest rate boundary, then a zero stamp that publishes
		write_rate(RATE_FASTEST);
		add_frame(8'd50, 32'd4577, 24'sd100, 24'sd200);
		add_frame(8'd70, 32'd4578, 24'sd300, 24'sd400);
		add_frame(8'd90, 32'd5000, 24'sd1, 24'sd2);
		add_frame(8'd30, 32'd0, 24'sd11, 24'sd12);
		add_frame(8'd40, 32'd9000, 24'sd13, 24'sd14);
		add_frame(8'd60, 32'd9100, 24'sd15, 24'sd16);
		drain();

		// slowest rate needs a second of elapsed time
		write_rate(RATE_SLOWEST);
		add_frame(8'd20, 32'd1_009_100, 24'sd21, 24'sd22);
		add_frame(8'd20, 32'd1_009_101, 24'sd23, 24'sd24);
		drain();

		clock_us = last_stamp;
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
			0: r = RATE_OFF;
			1: r = RATE_FASTEST;
			2: r = RATE_SLOWEST;
			3: r = 10'd1000;
			6: r = RATE_OFF;
			7: r = 10'd7;
			9: r = 10'd250;
			11: r = RATE_FASTEST;
			default: r = 10'($urandom_range(1, 1023));
			endcase
			no_idle = (ph % 4 == 2);
			write_rate(r);
			queue_random_frames(67, r);
			drain();
		end

		no_idle = 1'b0;
		write_rate(RATE_OFF);
		clock_us = last_stamp;
		queue_random_frames(20, RATE_OFF);
		drain();

		if (expected_results.size() != 0)
			mismatches++;
		$display("%0d frames through %0d rate settings: %0d published, %0d held",
			frames_taken, rate_writes, publishes, holds);
		$display("%0d results compared, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("tb_flow_rate_limit_accumulator: clean");
		end else begin
			$display("tb_flow_rate_limit_accumulator: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/frla_pkg.sv
rtl/frla_stream_if.sv
rtl/frla_div.sv
rtl/frla_dp.sv
rtl/frla_ctrl.sv
rtl/flow_rate_limit_accumulator.sv
tb/sv/tb_flow_rate_limit_accumulator.sv
